// ===== rtl/efr_pkg.sv =====
// Shared types for the exact Fresnel reflectance block.
// No dependencies; imported by the top level and the pipeline parts.
package efr_pkg;

    // Special-case flags that travel down the pipeline with each transaction
    typedef struct packed {
        logic tir;   // eta^2 + c^2 - 1 not positive
        logic zdiv;  // g + c or c(g - c) + 1 is zero
    } efr_flags_t;

endpackage

// ===== rtl/efr_if.sv =====
// Stream interfaces for the input cosine and the reflectance result.
// Depends on nothing; widths follow the fraction width.
interface efr_in_if #(parameter int FRAC_BITS = 16);
    logic                        valid;
    logic                        ready;
    logic signed [FRAC_BITS+1:0] cos_incidence;

    modport source (output valid, output cos_incidence, input ready);
    modport sink (input valid, input cos_incidence, output ready);
endinterface

interface efr_out_if #(parameter int FRAC_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   reflectance;
    logic                 total_reflection;
    logic                 saturated;

    modport source (output valid, output reflectance, output total_reflection,
                    output saturated, input ready);
    modport sink (input valid, input reflectance, input total_reflection,
                  input saturated, output ready);
endinterface

// ===== rtl/efr_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Uses efr_pkg; instantiated by the top level.
module efr_sqrt #(
    parameter int X_W    = 40,
    parameter int R_W    = 20,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [X_W-1:0]    x,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [R_W-1:0]    root,
    output logic [SIDE_W-1:0] side_out
);
    import efr_pkg::*;

    logic              v_reg    [R_W];
    logic [X_W-1:0]    rem_reg  [R_W];
    logic [R_W-1:0]    root_reg [R_W];
    logic [SIDE_W-1:0] side_reg [R_W];

    genvar s;
    generate
        for (s = 0; s < R_W; s++) begin : g_stage
            localparam int BIT = R_W - 1 - s;
            logic [X_W-1:0]   prev_rem;
            logic [R_W-1:0]   prev_root;
            logic             prev_v;
            logic [SIDE_W-1:0] prev_side;
            logic [X_W+1:0]   test;
            logic [X_W-1:0]   rem_next;
            logic [R_W-1:0]   root_next;

            // Take operands from the previous stage, or the input
            if (s == 0) begin : g_first
                assign prev_rem  = x;
                assign prev_root = '0;
                assign prev_v    = in_valid;
                assign prev_side = side_in;
            end else begin : g_rest
                assign prev_rem  = rem_reg[s-1];
                assign prev_root = root_reg[s-1];
                assign prev_v    = v_reg[s-1];
                assign prev_side = side_reg[s-1];
            end

            // Try one more root bit against the remainder
            always_comb
            begin
                test = (((X_W+2)'(prev_root) << 2) | (X_W+2)'(1)) << (2 * BIT);
                if ((X_W+2)'(prev_rem) >= test)
                begin
                    rem_next  = prev_rem - test[X_W-1:0];
                    root_next = (prev_root << 1) | R_W'(1);
                end
                else
                begin
                    rem_next  = prev_rem;
                    root_next = prev_root << 1;
                end
            end

            // Advance the stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[s] <= prev_v;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                    side_reg[s] <= prev_side;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[R_W-1];
    assign root      = root_reg[R_W-1];
    assign side_out  = side_reg[R_W-1];

endmodule

// ===== rtl/efr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Uses efr_pkg; instantiated twice by the top level.
module efr_div #(
    parameter int NUM_W  = 40,
    parameter int DEN_W  = 24,
    parameter int Q_W    = 25,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic              big,
    output logic [SIDE_W-1:0] side_out
);
    import efr_pkg::*;

    localparam int W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

    logic              v_reg    [Q_W+1];
    logic [W-1:0]      rem_reg  [Q_W+1];
    logic [Q_W-1:0]    q_reg    [Q_W+1];
    logic [DEN_W-1:0]  den_reg  [Q_W+1];
    logic              big_reg  [Q_W+1];
    logic [SIDE_W-1:0] side_reg [Q_W+1];

    // Stage zero: flag a quotient that does not fit in Q_W bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= W'(num);
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            big_reg[0]  <= W'(num) >= (W'(den) << Q_W);
            side_reg[0] <= side_in;
        end
    end

    genvar s;
    generate
        for (s = 1; s <= Q_W; s++) begin : g_stage
            localparam int BIT = Q_W - s;
            logic [W-1:0] dsh;
            logic         take;

            // Subtract the shifted divisor where it fits
            assign dsh  = W'(den_reg[s-1]) << BIT;
            assign take = rem_reg[s-1] >= dsh;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= take ? rem_reg[s-1] - dsh : rem_reg[s-1];
                    q_reg[s]    <= q_reg[s-1] | (Q_W'(take) << BIT);
                    den_reg[s]  <= den_reg[s-1];
                    big_reg[s]  <= big_reg[s-1];
                    side_reg[s] <= side_reg[s-1];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[Q_W];
    assign quot      = q_reg[Q_W];
    assign big       = big_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

// ===== rtl/exact_fresnel_reflectance_top.sv =====
// Exact unpolarized Fresnel reflectance of a dielectric: one transaction in,
// one transaction out, fully pipelined. A new cosine is taken every cycle
// while the output side keeps up. The pipeline holds the bit-per-stage
// square root (FRAC_BITS + 4 stages) and the bit-per-stage dividers
// (FRAC_BITS + 10 stages). A stall on the result holds the whole pipeline.
// Eta is written on wr_en/wr_data.
// Depends on efr_pkg, efr_if, efr_sqrt and efr_div.
module exact_fresnel_reflectance_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [FRAC_BITS+2:0] wr_data,
    efr_in_if.sink             sample,
    efr_out_if.source          result
);
    import efr_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int C_W  = F + 2;
    localparam int E_W  = F + 3;
    localparam int O_W  = F + 1;
    localparam int X_W  = 2 * F + 8;
    localparam int R_W  = F + 4;
    localparam int S_W  = F + 5;
    localparam int P_W  = 2 * F + 8;
    localparam int Q_W  = F + 9;
    localparam int A_W  = F + 3;
    localparam int BS_W = 2 * Q_W - F;
    localparam int T_W  = BS_W + 1;
    localparam int M_W  = A_W + T_W;
    localparam int FF_W = M_W - F - 1;

    localparam logic signed [X_W-1:0] ONE2_X = X_W'(1) << (2 * F);
    localparam logic signed [P_W-1:0] ONE2_P = P_W'(1) << (2 * F);
    localparam logic [Q_W-1:0]        TWO_Q  = Q_W'(1) << (F + 1);
    localparam logic [O_W-1:0]        ONE_O  = O_W'(1) << F;
    localparam logic [T_W-1:0]        ONE_T  = T_W'(1) << F;
    localparam logic [FF_W-1:0]       ONE_F  = FF_W'(1) << F;

    logic en;
    logic out_v_reg;

    // Hold everything when the result is not taken
    assign en           = !out_v_reg || result.ready;
    assign sample.ready = en;

    // Refractive index register
    logic [E_W-1:0] eta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_reg <= E_W'(3) << (F - 1);
        end
        else if (wr_en)
        begin
            eta_reg <= wr_data;
        end
    end

    // Stage 0: squares of eta and c
    logic                    v0_reg;
    logic signed [C_W-1:0]   c0_reg;
    logic [2*E_W-1:0]        e2_reg;
    logic signed [2*C_W-1:0] cc_reg;
    logic signed [2*C_W-1:0] cc_next;

    assign cc_next = sample.cos_incidence * sample.cos_incidence;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg <= sample.cos_incidence;
            e2_reg <= eta_reg * eta_reg;
            cc_reg <= cc_next;
        end
    end

    // Stage 1: g^2 and the total reflection test
    logic                  v1_reg;
    logic signed [C_W-1:0] c1_reg;
    logic [X_W-1:0]        g2_reg;
    logic                  tir1_reg;
    logic signed [X_W-1:0] g2_next;
    logic                  tir_next;

    assign g2_next  = $signed(X_W'(e2_reg)) + X_W'(cc_reg) - ONE2_X;
    assign tir_next = g2_next[X_W-1] || (g2_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= c0_reg;
            g2_reg   <= tir_next ? '0 : g2_next;
            tir1_reg <= tir_next;
        end
    end

    // Square root
    logic                  v2;
    logic [R_W-1:0]        g2root;
    logic [C_W:0]          side2;
    logic signed [C_W-1:0] c2;

    efr_sqrt #(
        .X_W    (X_W),
        .R_W    (R_W),
        .SIDE_W (C_W + 1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .x         (g2_reg),
        .side_in   ({tir1_reg, c1_reg}),
        .out_valid (v2),
        .root      (g2root),
        .side_out  (side2)
    );

    assign c2 = side2[C_W-1:0];

    // Stage A: g + c and g - c
    logic                  va_reg;
    logic signed [C_W-1:0] ca_reg;
    logic signed [S_W-1:0] sum_a_reg;
    logic signed [S_W-1:0] dif_a_reg;
    logic                  tira_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= v2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg    <= c2;
            sum_a_reg <= $signed({1'b0, g2root}) + S_W'(c2);
            dif_a_reg <= $signed({1'b0, g2root}) - S_W'(c2);
            tira_reg  <= side2[C_W];
        end
    end

    // Stage B: numerator and divisor of b, zero divisor test
    logic                  vb_reg;
    logic signed [S_W-1:0] sum_b_reg;
    logic signed [S_W-1:0] dif_b_reg;
    logic signed [P_W-1:0] nb_reg;
    logic signed [P_W-1:0] db_reg;
    efr_flags_t            fb_reg;
    logic signed [P_W-1:0] nb_next;
    logic signed [P_W-1:0] db_next;

    assign nb_next = P_W'(ca_reg) * P_W'(sum_a_reg) - ONE2_P;
    assign db_next = P_W'(ca_reg) * P_W'(dif_a_reg) + ONE2_P;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_b_reg   <= sum_a_reg;
            dif_b_reg   <= dif_a_reg;
            nb_reg      <= nb_next;
            db_reg      <= db_next;
            fb_reg.tir  <= tira_reg;
            fb_reg.zdiv <= (sum_a_reg == '0) || (db_next == '0);
        end
    end

    // Magnitudes into the dividers
    logic [S_W-1:0] mag_dif;
    logic [S_W-1:0] mag_sum;
    logic [P_W-1:0] mag_nb;
    logic [P_W-1:0] mag_db;

    assign mag_dif = dif_b_reg[S_W-1] ? S_W'(-dif_b_reg) : S_W'(dif_b_reg);
    assign mag_sum = sum_b_reg[S_W-1] ? S_W'(-sum_b_reg) : S_W'(sum_b_reg);
    assign mag_nb  = nb_reg[P_W-1] ? P_W'(-nb_reg) : P_W'(nb_reg);
    assign mag_db  = db_reg[P_W-1] ? P_W'(-db_reg) : P_W'(db_reg);

    logic           vda;
    logic           vdb;
    logic [Q_W-1:0] qa;
    logic [Q_W-1:0] qb;
    logic           big_a;
    logic           big_b;
    logic           tir_d;
    logic           zdiv_d;

    efr_div #(
        .NUM_W  (S_W + F),
        .DEN_W  (S_W),
        .Q_W    (Q_W),
        .SIDE_W (1)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb_reg),
        .num       ({mag_dif, {F{1'b0}}}),
        .den       (mag_sum),
        .side_in   (fb_reg.tir),
        .out_valid (vda),
        .quot      (qa),
        .big       (big_a),
        .side_out  (tir_d)
    );

    efr_div #(
        .NUM_W  (P_W + F),
        .DEN_W  (P_W),
        .Q_W    (Q_W),
        .SIDE_W (1)
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb_reg),
        .num       ({mag_nb, {F{1'b0}}}),
        .den       (mag_db),
        .side_in   (fb_reg.zdiv),
        .out_valid (vdb),
        .quot      (qb),
        .big       (big_b),
        .side_out  (zdiv_d)
    );

    // Stage M1: a^2 and b^2 products
    logic                vm1_reg;
    logic [A_W-1:0]      a2_reg;
    logic [2*Q_W-1:0]    bsq_reg;
    logic                asat_reg;
    logic                bbig1_reg;
    efr_flags_t          f1_reg;
    logic [F+1:0]        aq;
    logic [2*F+3:0]      aq_sq;

    assign aq    = qa[F+1:0];
    assign aq_sq = aq * aq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm1_reg <= 1'b0;
        end
        else if (en)
        begin
            vm1_reg <= vda && vdb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg      <= A_W'(aq_sq >> F);
            bsq_reg     <= qb * qb;
            asat_reg    <= big_a || (qa > TWO_Q);
            bbig1_reg   <= big_b;
            f1_reg.tir  <= tir_d;
            f1_reg.zdiv <= zdiv_d;
        end
    end

    // Stage M2: a^2 * (1 + b^2)
    logic            vm2_reg;
    logic [M_W-1:0]  prod_reg;
    logic            asat2_reg;
    logic            bbig2_reg;
    logic            a2z_reg;
    efr_flags_t      f2_reg;
    logic [T_W-1:0]  t_next;

    assign t_next = ONE_T + T_W'(bsq_reg >> F);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm2_reg <= 1'b0;
        end
        else if (en)
        begin
            vm2_reg <= vm1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= M_W'(a2_reg) * M_W'(t_next);
            asat2_reg <= asat_reg;
            bbig2_reg <= bbig1_reg;
            a2z_reg   <= (a2_reg == '0);
            f2_reg    <= f1_reg;
        end
    end

    // Output stage: pick the result by case priority
    logic [O_W-1:0]  refl_reg;
    logic            tir_reg;
    logic            sat_reg;
    logic [FF_W-1:0] f_val;
    logic [O_W-1:0]  refl_next;
    logic            tir_out_next;
    logic            sat_next;

    assign f_val = FF_W'(prod_reg >> (F + 1));

    always_comb
    begin
        refl_next    = ONE_O;
        tir_out_next = 1'b0;
        sat_next     = 1'b0;
        if (f2_reg.tir)
        begin
            tir_out_next = 1'b1;
        end
        else if (f2_reg.zdiv || asat2_reg)
        begin
            sat_next = 1'b1;
        end
        else if (a2z_reg)
        begin
            refl_next = '0;
        end
        else if (bbig2_reg || (f_val > ONE_F))
        begin
            sat_next = 1'b1;
        end
        else
        begin
            refl_next = O_W'(f_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= vm2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            refl_reg <= refl_next;
            tir_reg  <= tir_out_next;
            sat_reg  <= sat_next;
        end
    end

    assign result.valid            = out_v_reg;
    assign result.reflectance      = refl_reg;
    assign result.total_reflection = tir_reg;
    assign result.saturated        = sat_reg;

endmodule
